FILE: design/slrf_pkg.sv
// Package for the serpentine LED rectangle fill block.
// Holds the job and queue types, the back-end state enum and the colour scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slrf_pkg;

    // coordinate width follows the 4-bit size registers
    localparam int CW      = 4;
    localparam int IDX_W   = 6;
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [0:0] CFG_COLUMNS = 1'd0;
    localparam logic [0:0] CFG_ROWS    = 1'd1;

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_RECT   = 1'b1;

    // one non-empty fill, already clipped to the matrix
    typedef struct packed {
        logic          linear;   // whole-matrix fill: plain column-major index
        logic [CW-1:0] xs;
        logic [CW-1:0] xe;       // exclusive
        logic [CW-1:0] ys;
        logic [CW-1:0] ye;       // exclusive
        logic [7:0]    red;
        logic [7:0]    green;
        logic [7:0]    blue;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [7:0] scale_comp(input logic [7:0] c, input logic [7:0] b,
                                              input logic en);
        logic [15:0] prod;
        prod = 16'(c) * 16'(b);
        return en ? prod[15:8] : c;
    endfunction

endpackage

`default_nettype wire

FILE: design/slrf_if.sv
// Handshake channels of the fill block: the command channel and the LED channel.
// Depends on nothing; both carry valid, ready and their payload.
`timescale 1ns / 1ps
`default_nettype none

interface slrf_cmd_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [7:0] rect_x;
    logic signed [7:0] rect_y;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
    logic [7:0]        brightness;
    logic              scale_enable;

    modport source (output valid, kind, rect_x, rect_y, rect_width, rect_height,
                    red_in, green_in, blue_in, brightness, scale_enable,
                    input ready);
    modport sink   (input valid, kind, rect_x, rect_y, rect_width, rect_height,
                    red_in, green_in, blue_in, brightness, scale_enable,
                    output ready);
endinterface

interface slrf_led_if;
    logic       valid;
    logic       ready;
    logic [5:0] led_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last;

    modport source (output valid, led_index, red_out, green_out, blue_out, last,
                    input ready);
    modport sink   (input valid, led_index, red_out, green_out, blue_out, last,
                    output ready);
endinterface

`default_nettype wire

FILE: design/slrf_front.sv
// Front end: accepts fill commands, clips them to the matrix and scales the colour.
// Depends on slrf_pkg and slrf_cmd_if; fully clipped commands are dropped here.
`timescale 1ns / 1ps
`default_nettype none

module slrf_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    slrf_cmd_if.sink                 i_cmd,
    input  wire [slrf_pkg::CW-1:0]   i_cols,
    input  wire [slrf_pkg::CW-1:0]   i_rows,
    input  wire                      i_q_full,
    output logic                     o_push,
    output slrf_pkg::t_job           o_job
);
    import slrf_pkg::*;

    logic       r_valid;
    t_job       r_job;
    logic       w_take;
    t_job       w_job;
    logic       w_nonempty;

    logic signed [9:0] w_x0, w_y0, w_xe, w_ye, w_xs, w_ys, w_xc, w_yc;

    assign o_push      = r_valid && !i_q_full;
    assign o_job       = r_job;
    assign i_cmd.ready = !r_valid || !i_q_full;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        w_x0 = 10'(i_cmd.rect_x);
        w_y0 = 10'(i_cmd.rect_y);
        w_xe = w_x0 + $signed({2'b00, i_cmd.rect_width});
        w_ye = w_y0 + $signed({2'b00, i_cmd.rect_height});
        w_xs = w_x0[9] ? 10'sd0 : w_x0;
        w_ys = w_y0[9] ? 10'sd0 : w_y0;
        w_xc = (w_xe > $signed({6'd0, i_cols})) ? $signed({6'd0, i_cols}) : w_xe;
        w_yc = (w_ye > $signed({6'd0, i_rows})) ? $signed({6'd0, i_rows}) : w_ye;

        w_job.red   = scale_comp(i_cmd.red_in,   i_cmd.brightness, i_cmd.scale_enable);
        w_job.green = scale_comp(i_cmd.green_in, i_cmd.brightness, i_cmd.scale_enable);
        w_job.blue  = scale_comp(i_cmd.blue_in,  i_cmd.brightness, i_cmd.scale_enable);

        if (i_cmd.kind == KIND_MATRIX) begin
            w_job.linear = 1'b1;
            w_job.xs     = '0;
            w_job.xe     = i_cols;
            w_job.ys     = '0;
            w_job.ye     = i_rows;
            w_nonempty   = (i_cols != '0) && (i_rows != '0);
        end else begin
            // once non-empty, all bounds lie within 0..8
            w_job.linear = 1'b0;
            w_job.xs     = w_xs[CW-1:0];
            w_job.xe     = w_xc[CW-1:0];
            w_job.ys     = w_ys[CW-1:0];
            w_job.ye     = w_yc[CW-1:0];
            w_nonempty   = (w_xc > w_xs) && (w_yc > w_ys);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= w_nonempty;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job <= w_job;
        end
    end

endmodule

`default_nettype wire

FILE: design/slrf_queue.sv
// Short job queue between the front and back ends of the fill block.
// Depends on slrf_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module slrf_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  slrf_pkg::t_job       i_job,
    input  wire                  i_pop,
    output slrf_pkg::t_job       o_job,
    output slrf_pkg::t_q_status  o_status
);
    import slrf_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_status.full  = (r_cnt == QCW'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_job          = r_mem[r_rp];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: design/slrf_back.sv
// Back end: walks a clipped job column by column, one LED item per cycle unless
// o_led stalls. Depends on slrf_pkg and slrf_led_if; holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module slrf_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  slrf_pkg::t_job           i_job,
    input  slrf_pkg::t_q_status      i_q_status,
    output logic                     o_pop,
    input  wire [slrf_pkg::CW-1:0]   i_rows,
    slrf_led_if.source               o_led
);
    import slrf_pkg::*;

    t_back_state     r_state, n_state;
    t_job            r_job,   n_job;
    logic [CW-1:0]   r_x,     n_x;
    logic [CW-1:0]   r_y,     n_y;
    logic            r_ov,    n_ov;
    logic            w_emit;
    logic            w_adv;
    logic            w_x_end, w_y_end;
    logic [7:0]      w_base;
    logic [7:0]      w_idx;
    logic [CW-1:0]   w_off;

    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_red, r_green, r_blue;
    logic             r_last;

    assign w_adv   = !r_ov || o_led.ready;
    assign w_x_end = (r_x + 1'b1) == r_job.xe;
    assign w_y_end = (r_y + 1'b1) == r_job.ye;

    // even columns (and whole-matrix fills) count up, odd columns count down
    always_comb begin
        w_base = 8'(r_x) * 8'(i_rows);
        w_off  = (r_job.linear || !r_x[0]) ? r_y : (i_rows - 1'b1 - r_y);
        w_idx  = w_base + 8'(w_off);
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_x     = r_x;
        n_y     = r_y;
        n_ov    = r_ov;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        if (w_adv) begin
            n_ov = 1'b0;
        end
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_x     = i_job.xs;
                    n_y     = i_job.ys;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (w_adv) begin
                    w_emit = 1'b1;
                    n_ov   = 1'b1;
                    if (w_y_end) begin
                        n_y = r_job.ys;
                        n_x = r_x + 1'b1;
                        if (w_x_end) begin
                            n_state = BK_IDLE;
                        end
                    end else begin
                        n_y = r_y + 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_x   <= n_x;
        r_y   <= n_y;
        if (w_emit) begin
            r_idx   <= w_idx[IDX_W-1:0];
            r_red   <= r_job.red;
            r_green <= r_job.green;
            r_blue  <= r_job.blue;
            r_last  <= w_x_end && w_y_end;
        end
    end

    assign o_led.valid     = r_ov;
    assign o_led.led_index = r_idx;
    assign o_led.red_out   = r_red;
    assign o_led.green_out = r_green;
    assign o_led.blue_out  = r_blue;
    assign o_led.last      = r_last;

endmodule

`default_nettype wire

FILE: design/serpentine_led_rect_fill.sv
// Top level of the serpentine LED rectangle fill block.
// Depends on slrf_pkg, slrf_if, slrf_front, slrf_queue and slrf_back.
//
//  channel   dir  handshake          payload
//  i_cmd     in   valid / ready      kind, rect_x/y, rect_width/height, rgb, brightness
//  o_led     out  valid / ready      led_index, red/green/blue_out, last
//  i_cfg_*   in   write enable only  i_cfg_idx selects columns (0) or rows (1)
//
// The back end emits one LED item per cycle while o_led.ready is high; for each
// command it first loads the job from the queue, then emits an item per lit LED.
// The front end takes one command per cycle while the two-entry job queue has room.
// Reset is synchronous; it empties the pipeline and sets the matrix to 8 x 8.
// A low o_led.ready freezes the output register; the queue then fills and
// i_cmd.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module serpentine_led_rect_fill #(
    parameter int MAX_COLUMNS = 8,
    parameter int MAX_ROWS    = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    slrf_cmd_if.sink   i_cmd,
    slrf_led_if.source o_led,
    input  wire        i_cfg_we,
    input  wire [0:0]  i_cfg_idx,
    input  wire [3:0]  i_cfg_data
);
    import slrf_pkg::*;

    logic [CW-1:0] r_cols;
    logic [CW-1:0] r_rows;
    logic [CW-1:0] w_cols;
    logic [CW-1:0] w_rows;
    logic [7:0]    w_total;

    logic          w_push;
    logic          w_pop;
    t_job          w_front_job;
    t_job          w_q_job;
    t_q_status     w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 4'd8;
            r_rows <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_cols <= i_cfg_data;
                CFG_ROWS:    r_rows <= i_cfg_data;
                default:     r_cols <= r_cols;
            endcase
        end
    end

    // sizes above the maximum saturate
    assign w_cols  = (r_cols > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : r_cols;
    assign w_rows  = (r_rows > CW'(MAX_ROWS))    ? CW'(MAX_ROWS)    : r_rows;
    assign w_total = 8'(w_cols) * 8'(w_rows);

    slrf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_cols   (w_cols),
        .i_rows   (w_rows),
        .i_q_full (w_q_status.full),
        .o_push   (w_push),
        .o_job    (w_front_job)
    );

    slrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_q_job),
        .o_status (w_q_status)
    );

    slrf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_q_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .i_rows     (w_rows),
        .o_led      (o_led)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("job pushed into a full queue");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_status.empty))
        else $error("job popped from an empty queue");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_led.valid |-> (8'(o_led.led_index) < w_total))
        else $error("LED index beyond the matrix");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_led.valid)
        else $error("LED item shown right after reset");

endmodule

`default_nettype wire

FILE: tb/sv/serpentine_led_rect_fill_tb.sv
// Testbench for serpentine_led_rect_fill: directed and random fill commands
// checked LED by LED against a built-in model of the serpentine strip mapping.
// Depends on slrf_pkg, slrf_if and the design files.
`timescale 1ns / 1ps

module serpentine_led_rect_fill_tb;
    import slrf_pkg::*;

    localparam int GRID_MAX_COLS = 8;
    localparam int GRID_MAX_ROWS = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 80;     // a full 64-LED job plus queue slack
    localparam int BLOCK_ITEMS   = 29;

    typedef struct packed {
        logic              kind;
        logic signed [7:0] rect_x;
        logic signed [7:0] rect_y;
        logic [7:0]        rect_width;
        logic [7:0]        rect_height;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        brightness;
        logic              scale_enable;
    } fill_cmd_t;

    typedef struct packed {
        logic [5:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } led_write_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_idx;
    logic [3:0] cfg_data;

    slrf_cmd_if cmd_ch ();
    slrf_led_if led_ch ();

    // model copy of the size registers
    logic [3:0] grid_cols;
    logic [3:0] grid_rows;

    led_write_t pending_leds[$];
    led_write_t due_led;

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int fills_sent;
    int leds_checked;
    int matrix_settings;

    serpentine_led_rect_fill #(
        .MAX_COLUMNS(GRID_MAX_COLS),
        .MAX_ROWS   (GRID_MAX_ROWS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cmd     (cmd_ch),
        .o_led     (led_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] b,
                                               input logic en);
        int prod;
        prod = int'(c) * int'(b);
        return en ? 8'(prod >> 8) : c;
    endfunction

    // expands one command into the LED writes it must produce
    function automatic void expand_fill(input fill_cmd_t c);
        int         cols;
        int         rows;
        int         x0;
        int         y0;
        int         xe;
        int         ye;
        int         lit;
        int         pos;
        led_write_t w;
        cols = (grid_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(grid_cols);
        rows = (grid_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(grid_rows);
        w.red   = dim_channel(c.red, c.brightness, c.scale_enable);
        w.green = dim_channel(c.green, c.brightness, c.scale_enable);
        w.blue  = dim_channel(c.blue, c.brightness, c.scale_enable);
        w.last  = 1'b0;
        lit = 0;
        if (c.kind == KIND_MATRIX) begin
            for (int i = 0; i < cols * rows; i++) begin
                w.index = 6'(i);
                pending_leds.push_back(w);
                lit++;
            end
        end else begin
            // full-precision edges, no 8-bit wrap
            x0 = $signed(c.rect_x);
            y0 = $signed(c.rect_y);
            xe = x0 + int'(c.rect_width);
            ye = y0 + int'(c.rect_height);
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (xe > cols) xe = cols;
            if (ye > rows) ye = rows;
            for (int x = x0; x < xe; x++) begin
                for (int y = y0; y < ye; y++) begin
                    pos = (x % 2 == 0) ? x * rows + y : (x + 1) * rows - y - 1;
                    w.index = 6'(pos);
                    pending_leds.push_back(w);
                    lit++;
                end
            end
        end
        if (lit > 0) pending_leds[$].last = 1'b1;
    endfunction

    always @(posedge clk) begin
        if (rst_n && led_ch.valid && led_ch.ready) begin
            if (pending_leds.size() == 0) begin
                $error("LED item with nothing expected: led_index %0d", led_ch.led_index);
                errors++;
            end else begin
                due_led = pending_leds.pop_front();
                if (led_ch.led_index !== due_led.index) begin
                    $error("led_index: expected %0d, got %0d", due_led.index,
                           led_ch.led_index);
                    errors++;
                end
                if (led_ch.red_out !== due_led.red) begin
                    $error("red_out: expected %0d, got %0d", due_led.red, led_ch.red_out);
                    errors++;
                end
                if (led_ch.green_out !== due_led.green) begin
                    $error("green_out: expected %0d, got %0d", due_led.green,
                           led_ch.green_out);
                    errors++;
                end
                if (led_ch.blue_out !== due_led.blue) begin
                    $error("blue_out: expected %0d, got %0d", due_led.blue, led_ch.blue_out);
                    errors++;
                end
                if (led_ch.last !== due_led.last) begin
                    $error("last: expected %0d, got %0d", due_led.last, led_ch.last);
                    errors++;
                end
                leds_checked++;
            end
        end
        led_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_fill(input fill_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= c.kind;
        cmd_ch.rect_x       <= c.rect_x;
        cmd_ch.rect_y       <= c.rect_y;
        cmd_ch.rect_width   <= c.rect_width;
        cmd_ch.rect_height  <= c.rect_height;
        cmd_ch.red_in       <= c.red;
        cmd_ch.green_in     <= c.green;
        cmd_ch.blue_in      <= c.blue;
        cmd_ch.brightness   <= c.brightness;
        cmd_ch.scale_enable <= c.scale_enable;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        expand_fill(c);
        fills_sent++;
    endtask

    // waits for every expected LED, then lets empty commands flush out
    task automatic drain_leds();
        int waited;
        waited = 0;
        cmd_ch.valid <= 1'b0;
        while (pending_leds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_matrix(input logic [3:0] cols, input logic [3:0] rows);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_COLUMNS;
        cfg_data <= cols;
        @(posedge clk);
        grid_cols = cols;
        cfg_idx  <= CFG_ROWS;
        cfg_data <= rows;
        @(posedge clk);
        grid_rows = rows;
        cfg_we <= 1'b0;
        matrix_settings++;
    endtask

    function automatic fill_cmd_t whole_fill(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] bright,
                                             input logic scale);
        fill_cmd_t c;
        c = '0;
        c.kind         = KIND_MATRIX;
        c.rect_x       = 8'($urandom);
        c.rect_y       = 8'($urandom);
        c.rect_width   = 8'($urandom);
        c.rect_height  = 8'($urandom);
        c.red          = r;
        c.green        = g;
        c.blue         = b;
        c.brightness   = bright;
        c.scale_enable = scale;
        return c;
    endfunction

    function automatic fill_cmd_t rect_fill(input int x, input int y, input int w,
                                            input int h);
        fill_cmd_t c;
        c = whole_fill(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom));
        c.kind        = KIND_RECT;
        c.rect_x      = 8'(x);
        c.rect_y      = 8'(y);
        c.rect_width  = 8'(w);
        c.rect_height = 8'(h);
        return c;
    endfunction

    function automatic fill_cmd_t random_fill();
        fill_cmd_t c;
        int        sel;
        int        lvl;
        sel = $urandom_range(99);
        lvl = $urandom_range(9);
        if (sel < 30) begin
            c = rect_fill($urandom, $urandom, $urandom, $urandom);
            if (sel < 15) c.kind = KIND_MATRIX;
        end else begin
            // mostly rectangles around and across the matrix edges
            c = rect_fill(int'($urandom_range(12)) - 3, int'($urandom_range(12)) - 3,
                          $urandom_range(10), $urandom_range(10));
        end
        if (lvl == 0) c.brightness = 8'd0;
        else if (lvl == 1) c.brightness = 8'd255;
        return c;
    endfunction

    function automatic logic [3:0] random_extent();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 4'd0;
            1: return 4'($urandom_range(15, 9));
            2: return 4'd8;
            3: return 4'd1;
            default: return 4'($urandom_range(8, 1));
        endcase
    endfunction

    task automatic test_reset_matrix();
        send_fill(whole_fill(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0));
        send_fill(whole_fill(8'hFF, 8'h80, 8'h01, 8'hFF, 1'b1));
        send_fill(whole_fill(8'hAA, 8'h55, 8'hFF, 8'h00, 1'b1));
    endtask

    task automatic test_rect_clipping();
        send_fill(rect_fill(-128, -128, 255, 255));  // covers the whole matrix
        send_fill(rect_fill(127, 127, 255, 255));    // far off the matrix
        send_fill(rect_fill(0, 0, 0, 5));            // zero width
        send_fill(rect_fill(0, 0, 5, 0));            // zero height
        send_fill(rect_fill(2, 3, 3, 4));
        send_fill(rect_fill(-2, -1, 4, 3));
        send_fill(rect_fill(6, 6, 5, 5));
        send_fill(rect_fill(7, 0, 1, 8));            // single odd column, runs down
        send_fill(rect_fill(0, 7, 8, 1));
        send_fill(rect_fill(8, 0, 4, 4));            // just right of the matrix
        send_fill(rect_fill(-4, 0, 4, 4));           // ends exactly at column 0
        send_fill(rect_fill(-5, -3, 250, 251));      // would vanish with an 8-bit wrap
    endtask

    task automatic test_matrix_sizes();
        drain_leds();
        set_matrix(4'd0, 4'd8);                      // no columns: nothing lights
        send_fill(whole_fill(8'h12, 8'h34, 8'h56, 8'h80, 1'b1));
        send_fill(rect_fill(0, 0, 8, 8));
        drain_leds();
        set_matrix(4'd8, 4'd0);
        send_fill(whole_fill(8'h12, 8'h34, 8'h56, 8'h80, 1'b0));
        drain_leds();
        set_matrix(4'd15, 4'd15);                    // saturates to 8 x 8
        send_fill(whole_fill(8'h01, 8'h02, 8'h03, 8'hFF, 1'b1));
        send_fill(rect_fill(-1, -1, 20, 20));
        drain_leds();
        set_matrix(4'd1, 4'd1);
        send_fill(whole_fill(8'hFF, 8'h00, 8'hFF, 8'h7F, 1'b1));
        send_fill(rect_fill(0, 0, 1, 1));
        drain_leds();
        set_matrix(4'd3, 4'd5);
        send_fill(whole_fill(8'h40, 8'h80, 8'hC0, 8'h00, 1'b0));
        send_fill(rect_fill(1, 1, 2, 3));
    endtask

    task automatic test_random_fills(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            drain_leds();
            set_matrix(random_extent(), random_extent());
            for (int n = 0; n < BLOCK_ITEMS; n++) send_fill(random_fill());
        end
    endtask

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        errors          = 0;
        fills_sent      = 0;
        leds_checked    = 0;
        matrix_settings = 0;
        send_idle_pct   = 6;
        recv_stall_pct  = 46;
        grid_cols       = 4'd8;
        grid_rows       = 4'd8;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_COLUMNS;
        cfg_data            <= 4'd0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.kind         <= KIND_MATRIX;
        cmd_ch.rect_x       <= 8'sd0;
        cmd_ch.rect_y       <= 8'sd0;
        cmd_ch.rect_width   <= 8'd0;
        cmd_ch.rect_height  <= 8'd0;
        cmd_ch.red_in       <= 8'd0;
        cmd_ch.green_in     <= 8'd0;
        cmd_ch.blue_in      <= 8'd0;
        cmd_ch.brightness   <= 8'd0;
        cmd_ch.scale_enable <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_rect_clipping();
        test_matrix_sizes();
        test_random_fills(6, 46);
        test_random_fills(46, 6);
        test_random_fills(0, 0);
        drain_leds();

        if (pending_leds.size() != 0) begin
            $error("%0d expected LED items never arrived", pending_leds.size());
            errors += pending_leds.size();
        end
        $display("Sent %0d fill commands over %0d matrix sizes; checked %0d LED items.",
                 fills_sent, matrix_settings, leds_checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
